FILE: src/bhmcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhmcd_pkg
// Shared types and constants of the button hold and multi-click detector:
// event and configuration records, event kinds and register map.
// ----------------------------------------------------------------------------
package bhmcd_pkg;

    // widths fixed by the event and register formats
    localparam int EVT_COUNT_W = 16;
    localparam int BUTTON_ID_W = 8;
    localparam int TICKS_W     = 16;

    // apb register map: two 32-bit registers at byte offsets 0 and 4
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_LSB = 2;

    localparam logic REG_REPEAT_TICKS = 1'b0;
    localparam logic REG_BUTTON_ID    = 1'b1;

    // reset values of the registers
    localparam logic [TICKS_W-1:0]     REPEAT_TICKS_RST = 16'd50;
    localparam logic [BUTTON_ID_W-1:0] BUTTON_ID_RST    = 8'd0;

    // event kinds
    localparam logic KIND_HOLD  = 1'b0;
    localparam logic KIND_CLICK = 1'b1;

    typedef struct packed {
        logic [TICKS_W-1:0]     repeat_ticks;
        logic [BUTTON_ID_W-1:0] button_id;
    } bhmcd_cfg_t;

    typedef struct packed {
        logic                   kind;
        logic [EVT_COUNT_W-1:0] count;
        logic [BUTTON_ID_W-1:0] id;
    } bhmcd_event_t;

endpackage : bhmcd_pkg
`default_nettype wire

FILE: src/bhmcd_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhmcd_sample_if
// Valid/ready channel carrying one sampled button level per transaction.
// ----------------------------------------------------------------------------
interface bhmcd_sample_if;
    logic valid;
    logic ready;
    logic level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface : bhmcd_sample_if
`default_nettype wire

FILE: src/bhmcd_event_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhmcd_event_if
// Valid/ready channel carrying one hold or click event per transaction.
// ----------------------------------------------------------------------------
interface bhmcd_event_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [15:0] event_count;
    logic [7:0]  event_id;

    modport source (output valid, output event_kind, output event_count,
                    output event_id, input ready);
    modport sink   (input valid, input event_kind, input event_count,
                    input event_id, output ready);
endinterface : bhmcd_event_if
`default_nettype wire

FILE: src/button_hold_and_multi_click_detector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_hold_and_multi_click_detector_unit
// Top level: sample input register, detector state machine, event output
// register and APB configuration registers.
// ----------------------------------------------------------------------------
// Takes one sampled button level per transaction and returns at most one
// event for it: a hold event (kind 0) for each pressed sample from the second
// one on, or a click event (kind 1) after two released samples, carrying the
// running click count. A sample can be taken every cycle. Its event is
// offered from the output register: the sample waits in the input register
// while the state update works out its event, and the edge on which the
// sample moves on writes that event into the output register. The input stalls only
// while an event sits in the output register and is not being taken; the
// input register then still takes one more sample.
// repeat_ticks (offset 0) sets how many released samples clear the click
// count, button_id (offset 4) is echoed in every event. Write the registers
// only while the block is idle.
// ----------------------------------------------------------------------------
module button_hold_and_multi_click_detector_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bhmcd_sample_if.sink                           samples,
    bhmcd_event_if.source                          events,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bhmcd_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [bhmcd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [bhmcd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready
);
    import bhmcd_pkg::*;

    bhmcd_cfg_t   cfg;
    bhmcd_event_t evt;
    logic         evt_valid;

    logic         in_valid_reg,  in_valid_next;
    logic         level_reg;
    logic         out_valid_reg, out_valid_next;
    bhmcd_event_t out_evt_reg;
    logic         advance;

    // configuration registers
    bhmcd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sample moves on when the output register is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || events.ready);
    assign samples.ready = !in_valid_reg || advance;

    assign in_valid_next  = samples.ready ? samples.valid : in_valid_reg;
    assign out_valid_next = advance ? evt_valid : (out_valid_reg && !events.ready);

    // detector state machine
    bhmcd_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .level     (level_reg),
        .cfg       (cfg),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    // input and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            level_reg <= samples.level;
        end
        if (advance && evt_valid)
        begin
            out_evt_reg <= evt;
        end
    end

    assign events.valid       = out_valid_reg;
    assign events.event_kind  = out_evt_reg.kind;
    assign events.event_count = out_evt_reg.count;
    assign events.event_id    = out_evt_reg.id;

`ifndef SYNTHESIS
    // a waiting event is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && out_valid_reg && !events.ready))
        else $error("pending event overwritten");

    // an empty input register always takes a sample
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> samples.ready)
        else $error("input register empty but not ready");

    // an accepted sample lands in the input register
    a_sample_lands: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> in_valid_reg)
        else $error("accepted sample lost");
`endif

endmodule : button_hold_and_multi_click_detector_unit
`default_nettype wire

FILE: src/bhmcd_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhmcd_apb_regs
// APB configuration registers: window length in ticks and button id.
// ----------------------------------------------------------------------------
module bhmcd_apb_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bhmcd_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [bhmcd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [bhmcd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready,
    output bhmcd_pkg::bhmcd_cfg_t                  cfg
);
    import bhmcd_pkg::*;

    logic [TICKS_W-1:0]     repeat_ticks_reg;
    logic [BUTTON_ID_W-1:0] button_id_reg;
    logic                   wr_en;
    logic                   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_LSB];
    assign wr_en   = psel && penable && pwrite && pready;

    // register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_ticks_reg <= REPEAT_TICKS_RST;
            button_id_reg    <= BUTTON_ID_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_REPEAT_TICKS: repeat_ticks_reg <= pwdata[TICKS_W-1:0];
                REG_BUTTON_ID:    button_id_reg    <= pwdata[BUTTON_ID_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_REPEAT_TICKS: prdata = APB_DATA_W'(repeat_ticks_reg);
            REG_BUTTON_ID:    prdata = APB_DATA_W'(button_id_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.repeat_ticks = repeat_ticks_reg;
    assign cfg.button_id    = button_id_reg;

endmodule : bhmcd_apb_regs
`default_nettype wire

FILE: src/bhmcd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhmcd_ctrl
// Press/release state machine with hold and click counters and the click
// window timer. One sample is consumed per step; the event is combinational.
// ----------------------------------------------------------------------------
module bhmcd_ctrl #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  wire logic                     level,
    input  wire bhmcd_pkg::bhmcd_cfg_t    cfg,
    output logic                          evt_valid,
    output bhmcd_pkg::bhmcd_event_t       evt
);
    import bhmcd_pkg::*;

    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_ACTIVE   = 2'd1,
        ST_HOLD     = 2'd2,
        ST_RELEASED = 2'd3
    } state_t;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE   = COUNT_WIDTH'(1);
    localparam logic [TICKS_W-1:0]     TIMER_ONE = TICKS_W'(1);

    state_t                  state_reg,     state_next;
    logic [COUNT_WIDTH-1:0]  hold_cnt_reg,  hold_cnt_next;
    logic [COUNT_WIDTH-1:0]  click_cnt_reg, click_cnt_next;
    logic [TICKS_W-1:0]      timer_reg,     timer_next;
    logic [COUNT_WIDTH-1:0]  hold_cnt_inc;
    logic [COUNT_WIDTH-1:0]  click_cnt_inc;
    logic [COUNT_WIDTH-1:0]  evt_cnt;
    logic                    evt_kind;

    // saturating increments
    assign hold_cnt_inc  = (hold_cnt_reg == CNT_MAX)  ? hold_cnt_reg  : hold_cnt_reg + CNT_ONE;
    assign click_cnt_inc = (click_cnt_reg == CNT_MAX) ? click_cnt_reg : click_cnt_reg + CNT_ONE;

    // next state and event
    always_comb
    begin
        state_next     = state_reg;
        hold_cnt_next  = hold_cnt_reg;
        click_cnt_next = click_cnt_reg;
        timer_next     = timer_reg;
        evt_valid      = 1'b0;
        evt_kind       = KIND_HOLD;
        evt_cnt        = hold_cnt_reg;

        if (step)
        begin
            case (state_reg)
                ST_READY, ST_ACTIVE:
                begin
                    if (level && state_reg == ST_READY)
                    begin
                        state_next = ST_ACTIVE;
                    end
                    else if (level)
                    begin
                        // second pressed sample opens a hold at count zero
                        evt_valid     = 1'b1;
                        evt_cnt       = '0;
                        hold_cnt_next = CNT_ONE;
                        state_next    = ST_HOLD;
                    end
                    else
                    begin
                        // released sample runs the click window down
                        state_next = ST_READY;
                        if (timer_reg != '0)
                        begin
                            timer_next = timer_reg - TIMER_ONE;
                            if (timer_reg == TIMER_ONE)
                            begin
                                click_cnt_next = '0;
                            end
                        end
                    end
                end
                ST_HOLD:
                begin
                    if (level)
                    begin
                        evt_valid     = 1'b1;
                        hold_cnt_next = hold_cnt_inc;
                    end
                    else
                    begin
                        state_next = ST_RELEASED;
                    end
                end
                ST_RELEASED:
                begin
                    if (level)
                    begin
                        // one-sample release bridged, hold carries on
                        evt_valid     = 1'b1;
                        hold_cnt_next = hold_cnt_inc;
                        state_next    = ST_HOLD;
                    end
                    else
                    begin
                        evt_valid      = 1'b1;
                        evt_kind       = KIND_CLICK;
                        evt_cnt        = click_cnt_reg;
                        click_cnt_next = click_cnt_inc;
                        timer_next     = cfg.repeat_ticks;
                        state_next     = ST_READY;
                    end
                end
                default:
                begin
                    state_next = ST_READY;
                end
            endcase
        end
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            hold_cnt_reg  <= '0;
            click_cnt_reg <= '0;
            timer_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hold_cnt_reg  <= hold_cnt_next;
            click_cnt_reg <= click_cnt_next;
            timer_reg     <= timer_next;
        end
    end

    // clip or zero-pad the count to the event field width
    generate
        if (COUNT_WIDTH > EVT_COUNT_W)
        begin : g_clip
            assign evt.count = (|evt_cnt[COUNT_WIDTH-1:EVT_COUNT_W]) ?
                               '1 : evt_cnt[EVT_COUNT_W-1:0];
        end
        else if (COUNT_WIDTH == EVT_COUNT_W)
        begin : g_same
            assign evt.count = evt_cnt;
        end
        else
        begin : g_pad
            assign evt.count = {{(EVT_COUNT_W-COUNT_WIDTH){1'b0}}, evt_cnt};
        end
    endgenerate

    assign evt.kind = evt_kind;
    assign evt.id   = cfg.button_id;

`ifndef SYNTHESIS
    // a hold always opens at count zero
    a_hold_opens_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step && level && state_reg == ST_ACTIVE |-> evt_valid && evt.count == '0)
        else $error("hold did not open at count zero");

    // a click event reloads the window timer
    a_click_loads_timer: assert property (@(posedge clk) disable iff (!rst_n)
        step && evt_valid && evt.kind == KIND_CLICK |=>
            timer_reg == $past(cfg.repeat_ticks) && state_reg == ST_READY)
        else $error("click event did not reload the window timer");

    // no event without a step
    a_event_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> step)
        else $error("event raised without a step");
`endif

endmodule : bhmcd_ctrl
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button hold and multi-click detector. Sampled
// levels are pushed through the sample channel with random gaps. Each
// accepted transaction runs through a cycle-free model of the detector.
// Events taken from the event channel are compared field by field with the
// oldest pending prediction. Covers a directed opening, random press/release
// gestures under several register settings and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import bhmcd_pkg::*;

    localparam int CNT_W           = 16;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int PHASE_ITEMS     = 185;
    localparam int MAX_PRINTED     = 100;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_ACTIVE   = 2'd1,
        ST_HOLD     = 2'd2,
        ST_RELEASED = 2'd3
    } det_state_t;

    // one row of the opening sequence; typed rows carry their own expectation
    typedef struct packed {
        logic                   lvl;
        logic                   typed;
        logic                   fires;
        logic                   kind;
        logic [EVT_COUNT_W-1:0] count;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    bhmcd_sample_if samples_if ();
    bhmcd_event_if  events_if ();

    button_hold_and_multi_click_detector_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .events  (events_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // detector model state and its copy of the registers
    det_state_t             det_state = ST_READY;
    logic [CNT_W-1:0]       hold_cnt  = '0;
    logic [CNT_W-1:0]       click_cnt = '0;
    logic [TICKS_W-1:0]     win_timer = '0;
    logic [TICKS_W-1:0]     cfg_ticks = REPEAT_TICKS_RST;
    logic [BUTTON_ID_W-1:0] cfg_id    = BUTTON_ID_RST;

    bhmcd_event_t pending_events [$];
    int  error_count  = 0;
    int  items_sent   = 0;
    int  cycle_count  = 0;
    bit  tx_gaps      = 1'b1;
    bit  rx_stalls    = 1'b1;
    bit  hold_off_req = 1'b0;

    dir_row_t dir_rows [0:19] = '{
        '{1'b0, 1'b1, 1'b0, KIND_HOLD,  16'd0},  // released with timer idle
        '{1'b1, 1'b1, 1'b0, KIND_HOLD,  16'd0},  // arm
        '{1'b0, 1'b1, 1'b0, KIND_HOLD,  16'd0},  // one-sample press dropped
        '{1'b1, 1'b1, 1'b0, KIND_HOLD,  16'd0},
        '{1'b1, 1'b1, 1'b1, KIND_HOLD,  16'd0},  // hold starts at zero
        '{1'b1, 1'b1, 1'b1, KIND_HOLD,  16'd1},
        '{1'b1, 1'b1, 1'b1, KIND_HOLD,  16'd2},
        '{1'b0, 1'b1, 1'b0, KIND_HOLD,  16'd0},  // short release in hold
        '{1'b1, 1'b1, 1'b1, KIND_HOLD,  16'd3},  // bridged, count carries on
        '{1'b0, 1'b1, 1'b0, KIND_HOLD,  16'd0},
        '{1'b0, 1'b1, 1'b1, KIND_CLICK, 16'd0},  // first click
        '{1'b0, 1'b1, 1'b0, KIND_HOLD,  16'd0},  // window counts down
        '{1'b1, 1'b1, 1'b0, KIND_HOLD,  16'd0},
        '{1'b1, 1'b1, 1'b1, KIND_HOLD,  16'd0},  // hold count restarts
        '{1'b0, 1'b1, 1'b0, KIND_HOLD,  16'd0},
        '{1'b0, 1'b1, 1'b1, KIND_CLICK, 16'd1},  // second click
        '{1'b1, 1'b0, 1'b0, KIND_HOLD,  16'd0},
        '{1'b1, 1'b0, 1'b0, KIND_HOLD,  16'd0},
        '{1'b0, 1'b0, 1'b0, KIND_HOLD,  16'd0},
        '{1'b0, 1'b0, 1'b0, KIND_HOLD,  16'd0}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // idle length shared by sender gaps and receiver stalls
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic bhmcd_event_t make_event(input logic kind,
                                                input logic [CNT_W-1:0] cnt);
        bhmcd_event_t ev;
        ev.kind  = kind;
        ev.count = (cnt > CNT_W'(16'hFFFF)) ? 16'hFFFF : EVT_COUNT_W'(cnt);
        ev.id    = cfg_id;
        return ev;
    endfunction

    // released sample outside a hold: run the click window down
    function automatic void window_tick();
        if (win_timer != '0)
        begin
            win_timer--;
            if (win_timer == '0)
                click_cnt = '0;
        end
    endfunction

    // next state and event of the detector for one sampled level
    function automatic bit detector_step(input logic lvl, output bhmcd_event_t ev);
        bit fired;
        fired = 1'b0;
        ev    = '0;
        case (det_state)
            ST_READY:
            begin
                if (lvl)
                    det_state = ST_ACTIVE;
                else
                    window_tick();
            end
            ST_ACTIVE:
            begin
                if (lvl)
                begin
                    hold_cnt  = '0;
                    ev        = make_event(KIND_HOLD, hold_cnt);
                    hold_cnt  = sat_inc(hold_cnt);
                    fired     = 1'b1;
                    det_state = ST_HOLD;
                end
                else
                begin
                    window_tick();
                    det_state = ST_READY;
                end
            end
            ST_HOLD:
            begin
                if (lvl)
                begin
                    ev       = make_event(KIND_HOLD, hold_cnt);
                    hold_cnt = sat_inc(hold_cnt);
                    fired    = 1'b1;
                end
                else
                    det_state = ST_RELEASED;
            end
            default:
            begin
                if (lvl)
                begin
                    ev        = make_event(KIND_HOLD, hold_cnt);
                    hold_cnt  = sat_inc(hold_cnt);
                    fired     = 1'b1;
                    det_state = ST_HOLD;
                end
                else
                begin
                    win_timer = cfg_ticks;
                    ev        = make_event(KIND_CLICK, click_cnt);
                    click_cnt = sat_inc(click_cnt);
                    fired     = 1'b1;
                    det_state = ST_READY;
                end
            end
        endcase
        return fired;
    endfunction

    // one sample transaction; a typed expectation replaces the prediction
    task automatic send_level(input logic lvl, input bit typed = 1'b0,
                              input bit t_fires = 1'b0,
                              input bhmcd_event_t t_ev = '0);
        int gap;
        bit fired;
        bhmcd_event_t ev;
        gap = tx_gaps ? pick_idle() : 0;
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid <= 1'b1;
        samples_if.level <= lvl;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        fired = detector_step(lvl, ev);
        if (typed)
        begin
            fired = t_fires;
            ev    = t_ev;
        end
        if (fired)
            pending_events.push_back(ev);
        items_sent++;
    endtask

    // press run, optional short release inside the hold, then release run
    task automatic send_gesture();
        int presses;
        int releases;
        int r;
        r = $urandom_range(0, 99);
        presses = (r < 10) ? 1 : (r < 80) ? $urandom_range(2, 6) : $urandom_range(7, 30);
        r = $urandom_range(0, 99);
        releases = (r < 70) ? $urandom_range(2, 5) :
                   (r < 90) ? $urandom_range(6, 15) : $urandom_range(16, 60);
        repeat (presses) send_level(1'b1);
        if ($urandom_range(0, 4) == 0)
        begin
            send_level(1'b0);
            repeat ($urandom_range(1, 4)) send_level(1'b1);
        end
        repeat (releases) send_level(1'b0);
    endtask

    // wait until every predicted event has come, then let the pipe settle
    task automatic settle();
        int waited;
        waited = 0;
        samples_if.valid <= 1'b0;
        while (pending_events.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_events.size() != 0)
        begin
            flag_error($sformatf("%0d expected events never arrived",
                                 pending_events.size()));
            pending_events.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb transfer: setup, access until pready, then idle with psel low
    task automatic apb_access(input logic wr, input logic idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(idx) << REG_IDX_LSB;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic verify_register(input logic idx, input logic [APB_DATA_W-1:0] exp_val);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== exp_val)
            flag_error($sformatf("register %0d reads %h, expected %h", idx, rd, exp_val));
    endtask

    // write both registers with junk in the unused upper bits, then read back
    task automatic program_settings(input logic [TICKS_W-1:0] ticks,
                                    input logic [BUTTON_ID_W-1:0] id);
        logic [APB_DATA_W-1:0] word;
        logic [APB_DATA_W-1:0] unused;
        word = $urandom;
        word[TICKS_W-1:0] = ticks;
        apb_access(1'b1, REG_REPEAT_TICKS, word, unused);
        cfg_ticks = word[TICKS_W-1:0];
        word = $urandom;
        word[BUTTON_ID_W-1:0] = id;
        apb_access(1'b1, REG_BUTTON_ID, word, unused);
        cfg_id = word[BUTTON_ID_W-1:0];
        verify_register(REG_REPEAT_TICKS, APB_DATA_W'(cfg_ticks));
        verify_register(REG_BUTTON_ID, APB_DATA_W'(cfg_id));
    endtask

    // event receiver: random stalls, or one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        events_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                events_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (!rx_stalls)
                events_if.ready <= 1'b1;
            else
            begin
                if (stall_left == 0)
                    stall_left = pick_idle();
                if (stall_left > 0)
                begin
                    events_if.ready <= 1'b0;
                    stall_left--;
                end
                else
                    events_if.ready <= 1'b1;
            end
        end
    end

    // event checker
    always @(posedge clk)
    begin
        bhmcd_event_t exp_ev;
        if (rst_n && events_if.valid && events_if.ready)
        begin
            if (pending_events.size() == 0)
                flag_error($sformatf("unexpected event kind %0d count %0d id %0d",
                                     events_if.event_kind, events_if.event_count,
                                     events_if.event_id));
            else
            begin
                exp_ev = pending_events.pop_front();
                if (events_if.event_kind !== exp_ev.kind)
                    flag_error($sformatf("event_kind %0d, expected %0d",
                                         events_if.event_kind, exp_ev.kind));
                if (events_if.event_count !== exp_ev.count)
                    flag_error($sformatf("event_count %0d, expected %0d",
                                         events_if.event_count, exp_ev.count));
                if (events_if.event_id !== exp_ev.id)
                    flag_error($sformatf("event_id %0d, expected %0d",
                                         events_if.event_id, exp_ev.id));
            end
        end
    end

    // stimulus
    initial
    begin
        int target;
        logic [TICKS_W-1:0] ticks;
        logic [BUTTON_ID_W-1:0] id;
        bhmcd_event_t t_ev;

        rst_n            <= 1'b0;
        samples_if.valid <= 1'b0;
        samples_if.level <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers after reset
        verify_register(REG_REPEAT_TICKS, APB_DATA_W'(REPEAT_TICKS_RST));
        verify_register(REG_BUTTON_ID, APB_DATA_W'(BUTTON_ID_RST));

        // directed opening
        foreach (dir_rows[i])
        begin
            t_ev = '{kind: dir_rows[i].kind, count: dir_rows[i].count, id: cfg_id};
            send_level(dir_rows[i].lvl, dir_rows[i].typed, dir_rows[i].fires, t_ev);
        end
        settle();

        // random gestures under several register settings
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin ticks = 16'd3;     id = 8'hA5; end
                1: begin ticks = 16'd0;     id = 8'hFF; end
                2: begin ticks = 16'hFFFF;  id = 8'h00; end
                3: begin ticks = 16'd1;     id = 8'h3C; end
                4: begin
                    ticks = TICKS_W'($urandom_range(2, 12));
                    id    = BUTTON_ID_W'($urandom);
                end
                default: begin
                    ticks = TICKS_W'($urandom);
                    id    = BUTTON_ID_W'($urandom);
                end
            endcase
            program_settings(ticks, id);
            // one phase at full rate on both sides
            tx_gaps   = (phase != 3);
            rx_stalls = (phase != 3);
            if (phase == 1)
                hold_off_req = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_gesture();
                else
                    repeat ($urandom_range(1, 6)) send_level(1'($urandom_range(0, 1)));
            end
            settle();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule : tb
